@@ design/bf_pkg.sv @@
// Shared definitions for the Blowfish cipher core: codes, sizes, controller command struct
// and the initial subkey and S-box tables (hex fraction digits of pi). No dependencies.
package bf_pkg;

   localparam int SUBKEY_COUNT      = 18;
   localparam int BOX_COUNT         = 4;
   localparam int BOX_DEPTH         = 256;
   localparam int MAX_KEY_WORDS_DEF = 14;
   localparam int KEY_ADDR_W        = 5;   // covers up to 18 key words
   localparam int P_IDX_W           = 5;
   localparam int BOX_IDX_W         = 8;
   localparam int SCHED_IDX_W       = 10;  // flat S-box index, 4 x 256

   localparam logic [1:0] OP_KEY = 2'd0;
   localparam logic [1:0] OP_ENC = 2'd1;
   localparam logic [1:0] OP_DEC = 2'd2;

   localparam logic [1:0] STAT_BLOCK = 2'd0;
   localparam logic [1:0] STAT_TAKEN = 2'd1;
   localparam logic [1:0] STAT_SCHED = 2'd2;
   localparam logic [1:0] STAT_ERROR = 2'd3;

   typedef struct packed {
      logic                   key_wr;     // store req key word at key_addr
      logic [KEY_ADDR_W-1:0]  key_addr;   // key store write / read address
      logic                   p_init_wr;  // P[index] = init ^ key
      logic                   s_init_wr;  // all boxes [index] = init
      logic [SCHED_IDX_W-1:0] index;
      logic                   load;       // start block from request
      logic                   load_chain; // start block from last result
      logic                   round;
      logic                   finish;
      logic                   res_clear;
      logic [P_IDX_W-1:0]     p_idx;
      logic                   sched_wr_p;
      logic                   sched_wr_s;
      logic                   wr_half;    // 0 left half, 1 right half
      logic                   out_load;
      logic                   out_zero;
   } bf_cmd_type;

   localparam logic [31:0] P_INIT [SUBKEY_COUNT] = '{
      32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344, 32'ha4093822, 32'h299f31d0,
      32'h082efa98, 32'hec4e6c89, 32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
      32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917, 32'h9216d5d9, 32'h8979fb1b
   };

   localparam logic [31:0] S0_INIT [BOX_DEPTH] = '{
      32'hd1310ba6, 32'h98dfb5ac, 32'h2ffd72db, 32'hd01adfb7, 32'hb8e1afed, 32'h6a267e96,
      32'hba7c9045, 32'hf12c7f99, 32'h24a19947, 32'hb3916cf7, 32'h0801f2e2, 32'h858efc16,
      32'h636920d8, 32'h71574e69, 32'ha458fea3, 32'hf4933d7e, 32'h0d95748f, 32'h728eb658,
      32'h718bcd58, 32'h82154aee, 32'h7b54a41d, 32'hc25a59b5, 32'h9c30d539, 32'h2af26013,
      32'hc5d1b023, 32'h286085f0, 32'hca417918, 32'hb8db38ef, 32'h8e79dcb0, 32'h603a180e,
      32'h6c9e0e8b, 32'hb01e8a3e, 32'hd71577c1, 32'hbd314b27, 32'h78af2fda, 32'h55605c60,
      32'he65525f3, 32'haa55ab94, 32'h57489862, 32'h63e81440, 32'h55ca396a, 32'h2aab10b6,
      32'hb4cc5c34, 32'h1141e8ce, 32'ha15486af, 32'h7c72e993, 32'hb3ee1411, 32'h636fbc2a,
      32'h2ba9c55d, 32'h741831f6, 32'hce5c3e16, 32'h9b87931e, 32'hafd6ba33, 32'h6c24cf5c,
      32'h7a325381, 32'h28958677, 32'h3b8f4898, 32'h6b4bb9af, 32'hc4bfe81b, 32'h66282193,
      32'h61d809cc, 32'hfb21a991, 32'h487cac60, 32'h5dec8032, 32'hef845d5d, 32'he98575b1,
      32'hdc262302, 32'heb651b88, 32'h23893e81, 32'hd396acc5, 32'h0f6d6ff3, 32'h83f44239,
      32'h2e0b4482, 32'ha4842004, 32'h69c8f04a, 32'h9e1f9b5e, 32'h21c66842, 32'hf6e96c9a,
      32'h670c9c61, 32'habd388f0, 32'h6a51a0d2, 32'hd8542f68, 32'h960fa728, 32'hab5133a3,
      32'h6eef0b6c, 32'h137a3be4, 32'hba3bf050, 32'h7efb2a98, 32'ha1f1651d, 32'h39af0176,
      32'h66ca593e, 32'h82430e88, 32'h8cee8619, 32'h456f9fb4, 32'h7d84a5c3, 32'h3b8b5ebe,
      32'he06f75d8, 32'h85c12073, 32'h401a449f, 32'h56c16aa6, 32'h4ed3aa62, 32'h363f7706,
      32'h1bfedf72, 32'h429b023d, 32'h37d0d724, 32'hd00a1248, 32'hdb0fead3, 32'h49f1c09b,
      32'h075372c9, 32'h80991b7b, 32'h25d479d8, 32'hf6e8def7, 32'he3fe501a, 32'hb6794c3b,
      32'h976ce0bd, 32'h04c006ba, 32'hc1a94fb6, 32'h409f60c4, 32'h5e5c9ec2, 32'h196a2463,
      32'h68fb6faf, 32'h3e6c53b5, 32'h1339b2eb, 32'h3b52ec6f, 32'h6dfc511f, 32'h9b30952c,
      32'hcc814544, 32'haf5ebd09, 32'hbee3d004, 32'hde334afd, 32'h660f2807, 32'h192e4bb3,
      32'hc0cba857, 32'h45c8740f, 32'hd20b5f39, 32'hb9d3fbdb, 32'h5579c0bd, 32'h1a60320a,
      32'hd6a100c6, 32'h402c7279, 32'h679f25fe, 32'hfb1fa3cc, 32'h8ea5e9f8, 32'hdb3222f8,
      32'h3c7516df, 32'hfd616b15, 32'h2f501ec8, 32'had0552ab, 32'h323db5fa, 32'hfd238760,
      32'h53317b48, 32'h3e00df82, 32'h9e5c57bb, 32'hca6f8ca0, 32'h1a87562e, 32'hdf1769db,
      32'hd542a8f6, 32'h287effc3, 32'hac6732c6, 32'h8c4f5573, 32'h695b27b0, 32'hbbca58c8,
      32'he1ffa35d, 32'hb8f011a0, 32'h10fa3d98, 32'hfd2183b8, 32'h4afcb56c, 32'h2dd1d35b,
      32'h9a53e479, 32'hb6f84565, 32'hd28e49bc, 32'h4bfb9790, 32'he1ddf2da, 32'ha4cb7e33,
      32'h62fb1341, 32'hcee4c6e8, 32'hef20cada, 32'h36774c01, 32'hd07e9efe, 32'h2bf11fb4,
      32'h95dbda4d, 32'hae909198, 32'heaad8e71, 32'h6b93d5a0, 32'hd08ed1d0, 32'hafc725e0,
      32'h8e3c5b2f, 32'h8e7594b7, 32'h8ff6e2fb, 32'hf2122b64, 32'h8888b812, 32'h900df01c,
      32'h4fad5ea0, 32'h688fc31c, 32'hd1cff191, 32'hb3a8c1ad, 32'h2f2f2218, 32'hbe0e1777,
      32'hea752dfe, 32'h8b021fa1, 32'he5a0cc0f, 32'hb56f74e8, 32'h18acf3d6, 32'hce89e299,
      32'hb4a84fe0, 32'hfd13e0b7, 32'h7cc43b81, 32'hd2ada8d9, 32'h165fa266, 32'h80957705,
      32'h93cc7314, 32'h211a1477, 32'he6ad2065, 32'h77b5fa86, 32'hc75442f5, 32'hfb9d35cf,
      32'hebcdaf0c, 32'h7b3e89a0, 32'hd6411bd3, 32'hae1e7e49, 32'h00250e2d, 32'h2071b35e,
      32'h226800bb, 32'h57b8e0af, 32'h2464369b, 32'hf009b91e, 32'h5563911d, 32'h59dfa6aa,
      32'h78c14389, 32'hd95a537f, 32'h207d5ba2, 32'h02e5b9c5, 32'h83260376, 32'h6295cfa9,
      32'h11c81968, 32'h4e734a41, 32'hb3472dca, 32'h7b14a94a, 32'h1b510052, 32'h9a532915,
      32'hd60f573f, 32'hbc9bc6e4, 32'h2b60a476, 32'h81e67400, 32'h08ba6fb5, 32'h571be91f,
      32'hf296ec6b, 32'h2a0dd915, 32'hb6636521, 32'he7b9f9b6, 32'hff34052e, 32'hc5855664,
      32'h53b02d5d, 32'ha99f8fa1, 32'h08ba4799, 32'h6e85076a
   };

   localparam logic [31:0] S1_INIT [BOX_DEPTH] = '{
      32'h4b7a70e9, 32'hb5b32944, 32'hdb75092e, 32'hc4192623, 32'had6ea6b0, 32'h49a7df7d,
      32'h9cee60b8, 32'h8fedb266, 32'hecaa8c71, 32'h699a17ff, 32'h5664526c, 32'hc2b19ee1,
      32'h193602a5, 32'h75094c29, 32'ha0591340, 32'he4183a3e, 32'h3f54989a, 32'h5b429d65,
      32'h6b8fe4d6, 32'h99f73fd6, 32'ha1d29c07, 32'hefe830f5, 32'h4d2d38e6, 32'hf0255dc1,
      32'h4cdd2086, 32'h8470eb26, 32'h6382e9c6, 32'h021ecc5e, 32'h09686b3f, 32'h3ebaefc9,
      32'h3c971814, 32'h6b6a70a1, 32'h687f3584, 32'h52a0e286, 32'hb79c5305, 32'haa500737,
      32'h3e07841c, 32'h7fdeae5c, 32'h8e7d44ec, 32'h5716f2b8, 32'hb03ada37, 32'hf0500c0d,
      32'hf01c1f04, 32'h0200b3ff, 32'hae0cf51a, 32'h3cb574b2, 32'h25837a58, 32'hdc0921bd,
      32'hd19113f9, 32'h7ca92ff6, 32'h94324773, 32'h22f54701, 32'h3ae5e581, 32'h37c2dadc,
      32'hc8b57634, 32'h9af3dda7, 32'ha9446146, 32'h0fd0030e, 32'hecc8c73e, 32'ha4751e41,
      32'he238cd99, 32'h3bea0e2f, 32'h3280bba1, 32'h183eb331, 32'h4e548b38, 32'h4f6db908,
      32'h6f420d03, 32'hf60a04bf, 32'h2cb81290, 32'h24977c79, 32'h5679b072, 32'hbcaf89af,
      32'hde9a771f, 32'hd9930810, 32'hb38bae12, 32'hdccf3f2e, 32'h5512721f, 32'h2e6b7124,
      32'h501adde6, 32'h9f84cd87, 32'h7a584718, 32'h7408da17, 32'hbc9f9abc, 32'he94b7d8c,
      32'hec7aec3a, 32'hdb851dfa, 32'h63094366, 32'hc464c3d2, 32'hef1c1847, 32'h3215d908,
      32'hdd433b37, 32'h24c2ba16, 32'h12a14d43, 32'h2a65c451, 32'h50940002, 32'h133ae4dd,
      32'h71dff89e, 32'h10314e55, 32'h81ac77d6, 32'h5f11199b, 32'h043556f1, 32'hd7a3c76b,
      32'h3c11183b, 32'h5924a509, 32'hf28fe6ed, 32'h97f1fbfa, 32'h9ebabf2c, 32'h1e153c6e,
      32'h86e34570, 32'heae96fb1, 32'h860e5e0a, 32'h5a3e2ab3, 32'h771fe71c, 32'h4e3d06fa,
      32'h2965dcb9, 32'h99e71d0f, 32'h803e89d6, 32'h5266c825, 32'h2e4cc978, 32'h9c10b36a,
      32'hc6150eba, 32'h94e2ea78, 32'ha5fc3c53, 32'h1e0a2df4, 32'hf2f74ea7, 32'h361d2b3d,
      32'h1939260f, 32'h19c27960, 32'h5223a708, 32'hf71312b6, 32'hebadfe6e, 32'heac31f66,
      32'he3bc4595, 32'ha67bc883, 32'hb17f37d1, 32'h018cff28, 32'hc332ddef, 32'hbe6c5aa5,
      32'h65582185, 32'h68ab9802, 32'heecea50f, 32'hdb2f953b, 32'h2aef7dad, 32'h5b6e2f84,
      32'h1521b628, 32'h29076170, 32'hecdd4775, 32'h619f1510, 32'h13cca830, 32'heb61bd96,
      32'h0334fe1e, 32'haa0363cf, 32'hb5735c90, 32'h4c70a239, 32'hd59e9e0b, 32'hcbaade14,
      32'heecc86bc, 32'h60622ca7, 32'h9cab5cab, 32'hb2f3846e, 32'h648b1eaf, 32'h19bdf0ca,
      32'ha02369b9, 32'h655abb50, 32'h40685a32, 32'h3c2ab4b3, 32'h319ee9d5, 32'hc021b8f7,
      32'h9b540b19, 32'h875fa099, 32'h95f7997e, 32'h623d7da8, 32'hf837889a, 32'h97e32d77,
      32'h11ed935f, 32'h16681281, 32'h0e358829, 32'hc7e61fd6, 32'h96dedfa1, 32'h7858ba99,
      32'h57f584a5, 32'h1b227263, 32'h9b83c3ff, 32'h1ac24696, 32'hcdb30aeb, 32'h532e3054,
      32'h8fd948e4, 32'h6dbc3128, 32'h58ebf2ef, 32'h34c6ffea, 32'hfe28ed61, 32'hee7c3c73,
      32'h5d4a14d9, 32'he864b7e3, 32'h42105d14, 32'h203e13e0, 32'h45eee2b6, 32'ha3aaabea,
      32'hdb6c4f15, 32'hfacb4fd0, 32'hc742f442, 32'hef6abbb5, 32'h654f3b1d, 32'h41cd2105,
      32'hd81e799e, 32'h86854dc7, 32'he44b476a, 32'h3d816250, 32'hcf62a1f2, 32'h5b8d2646,
      32'hfc8883a0, 32'hc1c7b6a3, 32'h7f1524c3, 32'h69cb7492, 32'h47848a0b, 32'h5692b285,
      32'h095bbf00, 32'had19489d, 32'h1462b174, 32'h23820e00, 32'h58428d2a, 32'h0c55f5ea,
      32'h1dadf43e, 32'h233f7061, 32'h3372f092, 32'h8d937e41, 32'hd65fecf1, 32'h6c223bdb,
      32'h7cde3759, 32'hcbee7460, 32'h4085f2a7, 32'hce77326e, 32'ha6078084, 32'h19f8509e,
      32'he8efd855, 32'h61d99735, 32'ha969a7aa, 32'hc50c06c2, 32'h5a04abfc, 32'h800bcadc,
      32'h9e447a2e, 32'hc3453484, 32'hfdd56705, 32'h0e1e9ec9, 32'hdb73dbd3, 32'h105588cd,
      32'h675fda79, 32'he3674340, 32'hc5c43465, 32'h713e38d8, 32'h3d28f89e, 32'hf16dff20,
      32'h153e21e7, 32'h8fb03d4a, 32'he6e39f2b, 32'hdb83adf7
   };

   localparam logic [31:0] S2_INIT [BOX_DEPTH] = '{
      32'he93d5a68, 32'h948140f7, 32'hf64c261c, 32'h94692934, 32'h411520f7, 32'h7602d4f7,
      32'hbcf46b2e, 32'hd4a20068, 32'hd4082471, 32'h3320f46a, 32'h43b7d4b7, 32'h500061af,
      32'h1e39f62e, 32'h97244546, 32'h14214f74, 32'hbf8b8840, 32'h4d95fc1d, 32'h96b591af,
      32'h70f4ddd3, 32'h66a02f45, 32'hbfbc09ec, 32'h03bd9785, 32'h7fac6dd0, 32'h31cb8504,
      32'h96eb27b3, 32'h55fd3941, 32'hda2547e6, 32'habca0a9a, 32'h28507825, 32'h530429f4,
      32'h0a2c86da, 32'he9b66dfb, 32'h68dc1462, 32'hd7486900, 32'h680ec0a4, 32'h27a18dee,
      32'h4f3ffea2, 32'he887ad8c, 32'hb58ce006, 32'h7af4d6b6, 32'haace1e7c, 32'hd3375fec,
      32'hce78a399, 32'h406b2a42, 32'h20fe9e35, 32'hd9f385b9, 32'hee39d7ab, 32'h3b124e8b,
      32'h1dc9faf7, 32'h4b6d1856, 32'h26a36631, 32'heae397b2, 32'h3a6efa74, 32'hdd5b4332,
      32'h6841e7f7, 32'hca7820fb, 32'hfb0af54e, 32'hd8feb397, 32'h454056ac, 32'hba489527,
      32'h55533a3a, 32'h20838d87, 32'hfe6ba9b7, 32'hd096954b, 32'h55a867bc, 32'ha1159a58,
      32'hcca92963, 32'h99e1db33, 32'ha62a4a56, 32'h3f3125f9, 32'h5ef47e1c, 32'h9029317c,
      32'hfdf8e802, 32'h04272f70, 32'h80bb155c, 32'h05282ce3, 32'h95c11548, 32'he4c66d22,
      32'h48c1133f, 32'hc70f86dc, 32'h07f9c9ee, 32'h41041f0f, 32'h404779a4, 32'h5d886e17,
      32'h325f51eb, 32'hd59bc0d1, 32'hf2bcc18f, 32'h41113564, 32'h257b7834, 32'h602a9c60,
      32'hdff8e8a3, 32'h1f636c1b, 32'h0e12b4c2, 32'h02e1329e, 32'haf664fd1, 32'hcad18115,
      32'h6b2395e0, 32'h333e92e1, 32'h3b240b62, 32'heebeb922, 32'h85b2a20e, 32'he6ba0d99,
      32'hde720c8c, 32'h2da2f728, 32'hd0127845, 32'h95b794fd, 32'h647d0862, 32'he7ccf5f0,
      32'h5449a36f, 32'h877d48fa, 32'hc39dfd27, 32'hf33e8d1e, 32'h0a476341, 32'h992eff74,
      32'h3a6f6eab, 32'hf4f8fd37, 32'ha812dc60, 32'ha1ebddf8, 32'h991be14c, 32'hdb6e6b0d,
      32'hc67b5510, 32'h6d672c37, 32'h2765d43b, 32'hdcd0e804, 32'hf1290dc7, 32'hcc00ffa3,
      32'hb5390f92, 32'h690fed0b, 32'h667b9ffb, 32'hcedb7d9c, 32'ha091cf0b, 32'hd9155ea3,
      32'hbb132f88, 32'h515bad24, 32'h7b9479bf, 32'h763bd6eb, 32'h37392eb3, 32'hcc115979,
      32'h8026e297, 32'hf42e312d, 32'h6842ada7, 32'hc66a2b3b, 32'h12754ccc, 32'h782ef11c,
      32'h6a124237, 32'hb79251e7, 32'h06a1bbe6, 32'h4bfb6350, 32'h1a6b1018, 32'h11caedfa,
      32'h3d25bdd8, 32'he2e1c3c9, 32'h44421659, 32'h0a121386, 32'hd90cec6e, 32'hd5abea2a,
      32'h64af674e, 32'hda86a85f, 32'hbebfe988, 32'h64e4c3fe, 32'h9dbc8057, 32'hf0f7c086,
      32'h60787bf8, 32'h6003604d, 32'hd1fd8346, 32'hf6381fb0, 32'h7745ae04, 32'hd736fccc,
      32'h83426b33, 32'hf01eab71, 32'hb0804187, 32'h3c005e5f, 32'h77a057be, 32'hbde8ae24,
      32'h55464299, 32'hbf582e61, 32'h4e58f48f, 32'hf2ddfda2, 32'hf474ef38, 32'h8789bdc2,
      32'h5366f9c3, 32'hc8b38e74, 32'hb475f255, 32'h46fcd9b9, 32'h7aeb2661, 32'h8b1ddf84,
      32'h846a0e79, 32'h915f95e2, 32'h466e598e, 32'h20b45770, 32'h8cd55591, 32'hc902de4c,
      32'hb90bace1, 32'hbb8205d0, 32'h11a86248, 32'h7574a99e, 32'hb77f19b6, 32'he0a9dc09,
      32'h662d09a1, 32'hc4324633, 32'he85a1f02, 32'h09f0be8c, 32'h4a99a025, 32'h1d6efe10,
      32'h1ab93d1d, 32'h0ba5a4df, 32'ha186f20f, 32'h2868f169, 32'hdcb7da83, 32'h573906fe,
      32'ha1e2ce9b, 32'h4fcd7f52, 32'h50115e01, 32'ha70683fa, 32'ha002b5c4, 32'h0de6d027,
      32'h9af88c27, 32'h773f8641, 32'hc3604c06, 32'h61a806b5, 32'hf0177a28, 32'hc0f586e0,
      32'h006058aa, 32'h30dc7d62, 32'h11e69ed7, 32'h2338ea63, 32'h53c2dd94, 32'hc2c21634,
      32'hbbcbee56, 32'h90bcb6de, 32'hebfc7da1, 32'hce591d76, 32'h6f05e409, 32'h4b7c0188,
      32'h39720a3d, 32'h7c927c24, 32'h86e3725f, 32'h724d9db9, 32'h1ac15bb4, 32'hd39eb8fc,
      32'hed545578, 32'h08fca5b5, 32'hd83d7cd3, 32'h4dad0fc4, 32'h1e50ef5e, 32'hb161e6f8,
      32'ha28514d9, 32'h6c51133c, 32'h6fd5c7e7, 32'h56e14ec4, 32'h362abfce, 32'hddc6c837,
      32'hd79a3234, 32'h92638212, 32'h670efa8e, 32'h406000e0
   };

   localparam logic [31:0] S3_INIT [BOX_DEPTH] = '{
      32'h3a39ce37, 32'hd3faf5cf, 32'habc27737, 32'h5ac52d1b, 32'h5cb0679e, 32'h4fa33742,
      32'hd3822740, 32'h99bc9bbe, 32'hd5118e9d, 32'hbf0f7315, 32'hd62d1c7e, 32'hc700c47b,
      32'hb78c1b6b, 32'h21a19045, 32'hb26eb1be, 32'h6a366eb4, 32'h5748ab2f, 32'hbc946e79,
      32'hc6a376d2, 32'h6549c2c8, 32'h530ff8ee, 32'h468dde7d, 32'hd5730a1d, 32'h4cd04dc6,
      32'h2939bbdb, 32'ha9ba4650, 32'hac9526e8, 32'hbe5ee304, 32'ha1fad5f0, 32'h6a2d519a,
      32'h63ef8ce2, 32'h9a86ee22, 32'hc089c2b8, 32'h43242ef6, 32'ha51e03aa, 32'h9cf2d0a4,
      32'h83c061ba, 32'h9be96a4d, 32'h8fe51550, 32'hba645bd6, 32'h2826a2f9, 32'ha73a3ae1,
      32'h4ba99586, 32'hef5562e9, 32'hc72fefd3, 32'hf752f7da, 32'h3f046f69, 32'h77fa0a59,
      32'h80e4a915, 32'h87b08601, 32'h9b09e6ad, 32'h3b3ee593, 32'he990fd5a, 32'h9e34d797,
      32'h2cf0b7d9, 32'h022b8b51, 32'h96d5ac3a, 32'h017da67d, 32'hd1cf3ed6, 32'h7c7d2d28,
      32'h1f9f25cf, 32'hadf2b89b, 32'h5ad6b472, 32'h5a88f54c, 32'he029ac71, 32'he019a5e6,
      32'h47b0acfd, 32'hed93fa9b, 32'he8d3c48d, 32'h283b57cc, 32'hf8d56629, 32'h79132e28,
      32'h785f0191, 32'hed756055, 32'hf7960e44, 32'he3d35e8c, 32'h15056dd4, 32'h88f46dba,
      32'h03a16125, 32'h0564f0bd, 32'hc3eb9e15, 32'h3c9057a2, 32'h97271aec, 32'ha93a072a,
      32'h1b3f6d9b, 32'h1e6321f5, 32'hf59c66fb, 32'h26dcf319, 32'h7533d928, 32'hb155fdf5,
      32'h03563482, 32'h8aba3cbb, 32'h28517711, 32'hc20ad9f8, 32'habcc5167, 32'hccad925f,
      32'h4de81751, 32'h3830dc8e, 32'h379d5862, 32'h9320f991, 32'hea7a90c2, 32'hfb3e7bce,
      32'h5121ce64, 32'h774fbe32, 32'ha8b6e37e, 32'hc3293d46, 32'h48de5369, 32'h6413e680,
      32'ha2ae0810, 32'hdd6db224, 32'h69852dfd, 32'h09072166, 32'hb39a460a, 32'h6445c0dd,
      32'h586cdecf, 32'h1c20c8ae, 32'h5bbef7dd, 32'h1b588d40, 32'hccd2017f, 32'h6bb4e3bb,
      32'hdda26a7e, 32'h3a59ff45, 32'h3e350a44, 32'hbcb4cdd5, 32'h72eacea8, 32'hfa6484bb,
      32'h8d6612ae, 32'hbf3c6f47, 32'hd29be463, 32'h542f5d9e, 32'haec2771b, 32'hf64e6370,
      32'h740e0d8d, 32'he75b1357, 32'hf8721671, 32'haf537d5d, 32'h4040cb08, 32'h4eb4e2cc,
      32'h34d2466a, 32'h0115af84, 32'he1b00428, 32'h95983a1d, 32'h06b89fb4, 32'hce6ea048,
      32'h6f3f3b82, 32'h3520ab82, 32'h011a1d4b, 32'h277227f8, 32'h611560b1, 32'he7933fdc,
      32'hbb3a792b, 32'h344525bd, 32'ha08839e1, 32'h51ce794b, 32'h2f32c9b7, 32'ha01fbac9,
      32'he01cc87e, 32'hbcc7d1f6, 32'hcf0111c3, 32'ha1e8aac7, 32'h1a908749, 32'hd44fbd9a,
      32'hd0dadecb, 32'hd50ada38, 32'h0339c32a, 32'hc6913667, 32'h8df9317c, 32'he0b12b4f,
      32'hf79e59b7, 32'h43f5bb3a, 32'hf2d519ff, 32'h27d9459c, 32'hbf97222c, 32'h15e6fc2a,
      32'h0f91fc71, 32'h9b941525, 32'hfae59361, 32'hceb69ceb, 32'hc2a86459, 32'h12baa8d1,
      32'hb6c1075e, 32'he3056a0c, 32'h10d25065, 32'hcb03a442, 32'he0ec6e0e, 32'h1698db3b,
      32'h4c98a0be, 32'h3278e964, 32'h9f1f9532, 32'he0d392df, 32'hd3a0342b, 32'h8971f21e,
      32'h1b0a7441, 32'h4ba3348c, 32'hc5be7120, 32'hc37632d8, 32'hdf359f8d, 32'h9b992f2e,
      32'he60b6f47, 32'h0fe3f11d, 32'he54cda54, 32'h1edad891, 32'hce6279cf, 32'hcd3e7e6f,
      32'h1618b166, 32'hfd2c1d05, 32'h848fd2c5, 32'hf6fb2299, 32'hf523f357, 32'ha6327623,
      32'h93a83531, 32'h56cccd02, 32'hacf08162, 32'h5a75ebb5, 32'h6e163697, 32'h88d273cc,
      32'hde966292, 32'h81b949d0, 32'h4c50901b, 32'h71c65614, 32'he6c6c7bd, 32'h327a140a,
      32'h45e1d006, 32'hc3f27b9a, 32'hc9aa53fd, 32'h62a80f00, 32'hbb25bfe2, 32'h35bdd2f6,
      32'h71126905, 32'hb2040222, 32'hb6cbcf7c, 32'hcd769c2b, 32'h53113ec0, 32'h1640e3d3,
      32'h38abbd60, 32'h2547adf0, 32'hba38209c, 32'hf746ce76, 32'h77afa1c5, 32'h20756060,
      32'h85cbfe4e, 32'h8ae88dd8, 32'h7aaaf9b0, 32'h4cf9aa7e, 32'h1948c25c, 32'h02fb8a8c,
      32'h01c36ae4, 32'hd6ebe1f9, 32'h90d4f869, 32'ha65cdea0, 32'h3f09252d, 32'hc208e69f,
      32'hb74e6132, 32'hce77e25b, 32'h578fdfe3, 32'h3ac372e6
   };

endpackage

@@ design/blowfish_block_cipher_core.sv @@
// Top level of the Blowfish block cipher core: stream ports, controller and datapath.
// Depends on bf_pkg, bf_ctrl and bf_datapath.
//
//   channel  direction  carries
//   req_*    in         key words (op 0) and blocks to encrypt (op 1) or decrypt (op 2)
//   rsp_*    out        transformed block or zero, plus a status code, one per item
//
// A block passes through the round unit as a load on the accepting edge, 16 rounds and output
// whitening, one round per cycle, bound by the S-box read feeding the next round's address;
// the result is registered, then moved to the output register, and only then can the next
// item be taken. A key word that is not the last goes to a response and back to idle.
// The last key word starts the schedule: init of the 18 subkeys, init of the 256 S-box rows
// (all four boxes at once), then 521 chained encryptions, each followed by writes of the left
// and right result halves into the subkeys or S-boxes. One item is in flight at a time; reset
// clears the control state only, the S-boxes and subkeys hold nothing until a key is
// scheduled. A stalled result stays in the output register; the next item is still taken
// and processed, and its result then waits with req_tready low until the register frees.
module blowfish_block_cipher_core
   import bf_pkg::*;
#(
   parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // block_left[31:0], block_right[63:32], key_word[95:64]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        req_tlast,   // key_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_left[31:0], result_right[63:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   bf_cmd_type  cmd;
   logic [31:0] out_left;
   logic [31:0] out_right;

   bf_ctrl #(
      .MAX_KEY_WORDS(MAX_KEY_WORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd)
   );

   bf_datapath #(
      .MAX_KEY_WORDS(MAX_KEY_WORDS)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .in_left   (req_tdata[31:0]),
      .in_right  (req_tdata[63:32]),
      .in_key    (req_tdata[95:64]),
      .out_left  (out_left),
      .out_right (out_right)
   );

   assign rsp_tdata = {out_right, out_left};

endmodule

@@ design/bf_ctrl.sv @@
// Blowfish core controller: request decode, key collection, key schedule sequencing,
// cipher round counting and result handoff. Depends on bf_pkg.
module bf_ctrl
   import bf_pkg::*;
#(
   parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [1:0] rsp_tuser,
   output bf_cmd_type cmd
);

   localparam int KCNT_W = $clog2(MAX_KEY_WORDS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CIPHER = 3'd1;
   localparam logic [2:0] ST_PINIT  = 3'd2;
   localparam logic [2:0] ST_SINIT  = 3'd3;
   localparam logic [2:0] ST_WR_L   = 3'd4;
   localparam logic [2:0] ST_WR_R   = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   localparam logic [P_IDX_W-1:0]     LAST_ROUND = P_IDX_W'(SUBKEY_COUNT - 1);
   localparam logic [SCHED_IDX_W-1:0] P_LAST    = SCHED_IDX_W'(SUBKEY_COUNT - 1);
   localparam logic [SCHED_IDX_W-1:0] P_PAIR    = SCHED_IDX_W'(SUBKEY_COUNT - 2);
   localparam logic [SCHED_IDX_W-1:0] BOX_LAST  = SCHED_IDX_W'(BOX_DEPTH - 1);
   localparam logic [SCHED_IDX_W-1:0] S_PAIR    = SCHED_IDX_W'(BOX_COUNT * BOX_DEPTH - 2);

   logic [2:0]             state_ff, state_in;
   logic [P_IDX_W-1:0]     round_ff, round_in;
   logic [SCHED_IDX_W-1:0] index_ff, index_in;
   logic                   sbox_phase_ff, sbox_phase_in;
   logic                   dec_ff, dec_in;
   logic                   sched_ff, sched_in;
   logic [KCNT_W-1:0]      key_count_ff, key_count_in;
   logic [KCNT_W-1:0]      key_len_ff, key_len_in;
   logic [KCNT_W-1:0]      key_idx_ff, key_idx_in;
   logic                   key_ready_ff, key_ready_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [1:0]             pend_status_ff, pend_status_in;
   logic                   pend_zero_ff, pend_zero_in;
   logic                   accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      round_in       = round_ff;
      index_in       = index_ff;
      sbox_phase_in  = sbox_phase_ff;
      dec_in         = dec_ff;
      sched_in       = sched_ff;
      key_count_in   = key_count_ff;
      key_len_in     = key_len_ff;
      key_idx_in     = key_idx_ff;
      key_ready_in   = key_ready_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      pend_status_in = pend_status_ff;
      pend_zero_in   = pend_zero_ff;
      cmd            = '0;
      cmd.index      = index_ff;
      cmd.key_addr   = KEY_ADDR_W'(key_idx_ff);
      cmd.p_idx      = dec_ff ? (LAST_ROUND - round_ff) : round_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_KEY) begin
                  if (key_count_ff >= KCNT_W'(MAX_KEY_WORDS)) begin
                     // key store full: word dropped, last abandons collection
                     pend_status_in = STAT_ERROR;
                     pend_zero_in   = 1'b1;
                     if (req_tlast) begin
                        key_count_in = '0;
                     end
                     state_in = ST_RESP;
                  end else begin
                     cmd.key_wr   = 1'b1;
                     cmd.key_addr = KEY_ADDR_W'(key_count_ff);
                     if (req_tlast) begin
                        key_len_in    = key_count_ff + 1'b1;
                        key_count_in  = '0;
                        key_idx_in    = '0;
                        index_in      = '0;
                        cmd.res_clear = 1'b1;
                        state_in      = ST_PINIT;
                     end else begin
                        key_count_in   = key_count_ff + 1'b1;
                        pend_status_in = STAT_TAKEN;
                        pend_zero_in   = 1'b1;
                        state_in       = ST_RESP;
                     end
                  end
               end else if ((req_tuser == OP_ENC || req_tuser == OP_DEC) && key_ready_ff) begin
                  cmd.load  = 1'b1;
                  cmd.p_idx = (req_tuser == OP_DEC) ? LAST_ROUND : '0;
                  dec_in    = (req_tuser == OP_DEC);
                  sched_in  = 1'b0;
                  round_in  = P_IDX_W'(1);
                  state_in  = ST_CIPHER;
               end else begin
                  pend_status_in = STAT_ERROR;
                  pend_zero_in   = 1'b1;
                  state_in       = ST_RESP;
               end
            end
         end
         ST_CIPHER: begin
            round_in = round_ff + 1'b1;
            if (round_ff == '0) begin
               cmd.load_chain = 1'b1;
            end else if (round_ff != LAST_ROUND) begin
               cmd.round = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               if (sched_ff) begin
                  state_in = ST_WR_L;
               end else begin
                  pend_status_in = STAT_BLOCK;
                  pend_zero_in   = 1'b0;
                  state_in       = ST_RESP;
               end
            end
         end
         ST_PINIT: begin
            cmd.p_init_wr = 1'b1;
            key_idx_in    = (key_idx_ff + 1'b1 == key_len_ff) ? '0 : key_idx_ff + 1'b1;
            if (index_ff == P_LAST) begin
               index_in = '0;
               state_in = ST_SINIT;
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         ST_SINIT: begin
            cmd.s_init_wr = 1'b1;
            if (index_ff == BOX_LAST) begin
               index_in      = '0;
               sbox_phase_in = 1'b0;
               round_in      = '0;
               sched_in      = 1'b1;
               dec_in        = 1'b0;
               state_in      = ST_CIPHER;
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         ST_WR_L: begin
            cmd.sched_wr_p = !sbox_phase_ff;
            cmd.sched_wr_s = sbox_phase_ff;
            cmd.wr_half    = 1'b0;
            state_in       = ST_WR_R;
         end
         ST_WR_R: begin
            cmd.sched_wr_p = !sbox_phase_ff;
            cmd.sched_wr_s = sbox_phase_ff;
            cmd.wr_half    = 1'b1;
            cmd.index      = index_ff | SCHED_IDX_W'(1);
            round_in       = '0;
            if (!sbox_phase_ff && index_ff == P_PAIR) begin
               sbox_phase_in = 1'b1;
               index_in      = '0;
               state_in      = ST_CIPHER;
            end else if (sbox_phase_ff && index_ff == S_PAIR) begin
               key_ready_in   = 1'b1;
               pend_status_in = STAT_SCHED;
               pend_zero_in   = 1'b1;
               state_in       = ST_RESP;
            end else begin
               index_in = index_ff + SCHED_IDX_W'(2);
               state_in = ST_CIPHER;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               cmd.out_zero  = pend_zero_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff       <= round_in;
      index_ff       <= index_in;
      sbox_phase_ff  <= sbox_phase_in;
      dec_ff         <= dec_in;
      sched_ff       <= sched_in;
      key_len_ff     <= key_len_in;
      key_idx_ff     <= key_idx_in;
      rsp_status_ff  <= rsp_status_in;
      pend_status_ff <= pend_status_in;
      pend_zero_ff   <= pend_zero_in;
   end

endmodule

@@ design/bf_datapath.sv @@
// Blowfish core datapath: key store, subkey registers, four S-box memories, the Feistel
// round unit and the result registers. Driven by bf_ctrl commands. Depends on bf_pkg.
module bf_datapath
   import bf_pkg::*;
#(
   parameter int MAX_KEY_WORDS = MAX_KEY_WORDS_DEF
) (
   input  logic        clock,
   input  bf_cmd_type  cmd,
   input  logic [31:0] in_left,
   input  logic [31:0] in_right,
   input  logic [31:0] in_key,
   output logic [31:0] out_left,
   output logic [31:0] out_right
);

   localparam int KIDX_W = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

   logic [31:0] key_store [MAX_KEY_WORDS];
   logic [31:0] p_arr [SUBKEY_COUNT];
   logic [31:0] sbox_mem [BOX_COUNT][BOX_DEPTH];
   logic [31:0] sdata_ff [BOX_COUNT];

   logic [31:0] xl_ff, xl_in;
   logic [31:0] xr_ff, xr_in;
   logic [31:0] res_l_ff, res_l_in;
   logic [31:0] res_r_ff, res_r_in;
   logic [31:0] out_l_ff, out_l_in;
   logic [31:0] out_r_ff, out_r_in;

   logic [31:0]          p_rd;
   logic [31:0]          key_rd;
   logic [31:0]          feistel;
   logic [31:0]          next_l;
   logic [31:0]          wr_data;
   logic [BOX_IDX_W-1:0] rd_addr [BOX_COUNT];
   logic [31:0]          init_word [BOX_COUNT];

   assign p_rd   = p_arr[cmd.p_idx];
   assign key_rd = key_store[cmd.key_addr[KIDX_W-1:0]];

   // F(x) = ((S0[a] + S1[b]) ^ S2[c]) + S3[d]
   assign feistel = ((sdata_ff[0] + sdata_ff[1]) ^ sdata_ff[2]) + sdata_ff[3];

   always_comb begin
      if (cmd.load) begin
         next_l = in_left ^ p_rd;
      end else if (cmd.load_chain) begin
         next_l = res_l_ff ^ p_rd;
      end else begin
         next_l = xr_ff ^ feistel ^ p_rd;
      end
   end

   // box 0 takes the top byte
   always_comb begin
      for (int b = 0; b < BOX_COUNT; b++) begin
         rd_addr[b] = next_l[(BOX_COUNT - 1 - b) * BOX_IDX_W +: BOX_IDX_W];
      end
   end

   assign init_word[0] = S0_INIT[cmd.index[BOX_IDX_W-1:0]];
   assign init_word[1] = S1_INIT[cmd.index[BOX_IDX_W-1:0]];
   assign init_word[2] = S2_INIT[cmd.index[BOX_IDX_W-1:0]];
   assign init_word[3] = S3_INIT[cmd.index[BOX_IDX_W-1:0]];

   assign wr_data = cmd.wr_half ? res_r_ff : res_l_ff;

   for (genvar b = 0; b < BOX_COUNT; b++) begin : g_box
      always_ff @(posedge clock) begin
         if (cmd.s_init_wr) begin
            sbox_mem[b][cmd.index[BOX_IDX_W-1:0]] <= init_word[b];
         end else if (cmd.sched_wr_s &&
                      cmd.index[SCHED_IDX_W-1:BOX_IDX_W] == (SCHED_IDX_W - BOX_IDX_W)'(b)) begin
            sbox_mem[b][cmd.index[BOX_IDX_W-1:0]] <= wr_data;
         end
         sdata_ff[b] <= sbox_mem[b][rd_addr[b]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_wr) begin
         key_store[cmd.key_addr[KIDX_W-1:0]] <= in_key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.p_init_wr) begin
         p_arr[cmd.index[P_IDX_W-1:0]] <= P_INIT[cmd.index[P_IDX_W-1:0]] ^ key_rd;
      end else if (cmd.sched_wr_p) begin
         p_arr[cmd.index[P_IDX_W-1:0]] <= wr_data;
      end
   end

   always_comb begin
      xl_in    = xl_ff;
      xr_in    = xr_ff;
      res_l_in = res_l_ff;
      res_r_in = res_r_ff;
      out_l_in = out_l_ff;
      out_r_in = out_r_ff;
      if (cmd.load) begin
         xl_in = next_l;
         xr_in = in_right;
      end else if (cmd.load_chain) begin
         xl_in = next_l;
         xr_in = res_r_ff;
      end else if (cmd.round) begin
         xl_in = next_l;
         xr_in = xl_ff;
      end
      // last step: undo the swap and apply the final subkey
      if (cmd.finish) begin
         res_l_in = xr_ff ^ p_rd;
         res_r_in = xl_ff;
      end else if (cmd.res_clear) begin
         res_l_in = '0;
         res_r_in = '0;
      end
      if (cmd.out_load) begin
         out_l_in = cmd.out_zero ? '0 : res_l_ff;
         out_r_in = cmd.out_zero ? '0 : res_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      xl_ff    <= xl_in;
      xr_ff    <= xr_in;
      res_l_ff <= res_l_in;
      res_r_ff <= res_r_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
   end

   assign out_left  = out_l_ff;
   assign out_right = out_r_ff;

endmodule

@@ tb/blowfish_block_cipher_checker.sv @@
// Checker for the Blowfish core: watches both stream channels, predicts every result
// with its own key schedule and cipher, and counts mismatches. Depends on bf_pkg.
module blowfish_block_cipher_checker
   import bf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
      logic [1:0]  status;
   } cipher_result_type;

   localparam int KEY_WORDS = MAX_KEY_WORDS_DEF;

   cipher_result_type result_queue[$];
   logic [31:0]       subkeys [SUBKEY_COUNT];
   logic [31:0]       sboxes [BOX_COUNT*BOX_DEPTH];
   logic [31:0]       key_words [KEY_WORDS];
   int                words_held;
   logic              have_key;

   function automatic logic [31:0] mix(input logic [31:0] x);
      logic [31:0] a, b, c, d;
      a = sboxes[x[31:24]];
      b = sboxes[BOX_DEPTH + x[23:16]];
      c = sboxes[2*BOX_DEPTH + x[15:8]];
      d = sboxes[3*BOX_DEPTH + x[7:0]];
      return ((a + b) ^ c) + d;
   endfunction

   // returns {left, right}
   function automatic logic [63:0] crypt(input logic [31:0] l, input logic [31:0] r,
                                         input logic decrypt);
      logic [31:0] xl, xr, t;
      xl = l;
      xr = r;
      for (int i = 0; i < SUBKEY_COUNT - 2; i++) begin
         xl ^= subkeys[decrypt ? SUBKEY_COUNT - 1 - i : i];
         xr ^= mix(xl);
         t = xl; xl = xr; xr = t;
      end
      t = xl; xl = xr; xr = t;
      xr ^= subkeys[decrypt ? 1 : SUBKEY_COUNT - 2];
      xl ^= subkeys[decrypt ? 0 : SUBKEY_COUNT - 1];
      return {xl, xr};
   endfunction

   task automatic expand_key(input int n);
      logic [63:0] blk;
      blk = '0;
      for (int i = 0; i < SUBKEY_COUNT; i++)
         subkeys[i] = P_INIT[i] ^ key_words[i % n];
      for (int i = 0; i < BOX_DEPTH; i++) begin
         sboxes[i]               = S0_INIT[i];
         sboxes[BOX_DEPTH + i]   = S1_INIT[i];
         sboxes[2*BOX_DEPTH + i] = S2_INIT[i];
         sboxes[3*BOX_DEPTH + i] = S3_INIT[i];
      end
      for (int i = 0; i < SUBKEY_COUNT; i += 2) begin
         blk = crypt(blk[63:32], blk[31:0], 1'b0);
         subkeys[i]     = blk[63:32];
         subkeys[i + 1] = blk[31:0];
      end
      for (int i = 0; i < BOX_COUNT*BOX_DEPTH; i += 2) begin
         blk = crypt(blk[63:32], blk[31:0], 1'b0);
         sboxes[i]     = blk[63:32];
         sboxes[i + 1] = blk[31:0];
      end
   endtask

   task automatic predict(input logic [1:0] op, input logic [95:0] data, input logic last);
      cipher_result_type exp_res;
      logic [63:0]       blk;
      exp_res = '0;
      if (op == OP_KEY) begin
         if (words_held >= KEY_WORDS) begin
            exp_res.status = STAT_ERROR;
            if (last) words_held = 0;
         end else begin
            key_words[words_held] = data[95:64];
            words_held++;
            if (last) begin
               expand_key(words_held);
               have_key   = 1'b1;
               words_held = 0;
               exp_res.status = STAT_SCHED;
            end else begin
               exp_res.status = STAT_TAKEN;
            end
         end
      end else if ((op == OP_ENC || op == OP_DEC) && have_key) begin
         blk = crypt(data[31:0], data[63:32], op == OP_DEC);
         exp_res.left   = blk[63:32];
         exp_res.right  = blk[31:0];
         exp_res.status = STAT_BLOCK;
      end else begin
         exp_res.status = STAT_ERROR;
      end
      result_queue.push_back(exp_res);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cipher_result_type head;
      if (reset) begin
         result_queue.delete();
         words_held = 0;
         have_key   = 1'b0;
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               report("unexpected result", {30'd0, rsp_tuser}, 32'd0);
            end else begin
               head = result_queue.pop_front();
               if (rsp_tdata[31:0] !== head.left)
                  report("result_left", rsp_tdata[31:0], head.left);
               if (rsp_tdata[63:32] !== head.right)
                  report("result_right", rsp_tdata[63:32], head.right);
               if (rsp_tuser !== head.status)
                  report("status", {30'd0, rsp_tuser}, {30'd0, head.status});
            end
         end
         if (req_tvalid && req_tready)
            predict(req_tuser, req_tdata, req_tlast);
      end
      pending_count = result_queue.size();
   end

endmodule

@@ tb/blowfish_block_cipher_core_tb.sv @@
// Testbench top for the Blowfish core: clock, reset, bursty item stimulus, result stalls
// and the verdict. Depends on bf_pkg, blowfish_block_cipher_core and the checker.
module blowfish_block_cipher_core_tb;
   import bf_pkg::*;

   localparam int IDLE_LIMIT = 60000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;        // block_left, block_right, key_word
   logic [1:0]  req_tuser = OP_KEY;    // operation
   logic        req_tlast = 1'b0;      // key_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;             // result_left, result_right
   logic [1:0]  rsp_tuser;             // status
   int          fail_count;
   int          pending_count;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          stall_mode = 0;

   blowfish_block_cipher_core dut (.*);

   blowfish_block_cipher_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: three stall styles picked at random; mode 0 never stalls
   int rx_cycle = 0;
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one item; called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [1:0] op, input logic [31:0] left,
                            input logic [31:0] right, input logic [31:0] kw,
                            input logic last);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {kw, right, left};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic send_block(input logic [1:0] op);
      send_item(op, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
   endtask

   // key of n words; overfill adds extra words after a full store
   task automatic load_key(input int n, input bit overfill, input bit abandon);
      for (int i = 0; i < n; i++)
         send_item(OP_KEY, $urandom, $urandom, $urandom, !overfill && i == n - 1);
      if (overfill) begin
         repeat ($urandom_range(0, 2)) send_item(OP_KEY, $urandom, $urandom, $urandom, 1'b0);
         send_item(OP_KEY, $urandom, $urandom, $urandom, abandon);
      end
   endtask

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no key yet: ciphers and the unknown operation all error
      send_item(OP_ENC, '1, '0, '1, 1'b0);
      send_item(OP_DEC, '0, '1, '0, 1'b1);
      send_item(2'd3, '1, '1, '1, 1'b1);
      // one-word key, all ones
      send_item(OP_KEY, '0, '0, '1, 1'b1);
      send_item(OP_ENC, '0, '0, '0, 1'b0);
      send_item(OP_ENC, '1, '1, '1, 1'b1);
      send_item(OP_DEC, '0, '0, '1, 1'b0);
      send_item(OP_DEC, '1, '1, '0, 1'b1);
      send_item(2'd3, '0, '0, '0, 1'b0);
      // all-zero key word
      send_item(OP_KEY, '1, '1, '0, 1'b1);
      send_item(OP_ENC, 32'h80000000, 32'h00000001, '0, 1'b0);
      // a full key, then extra words abandoned; the old key stays
      load_key(MAX_KEY_WORDS_DEF, 1'b1, 1'b1);
      send_item(OP_ENC, 32'h01234567, 32'h89abcdef, '0, 1'b0);
      // partial collection pending while a block goes through
      send_item(OP_KEY, '0, '0, 32'hdeadbeef, 1'b0);
      send_item(OP_DEC, 32'h01234567, 32'h89abcdef, '0, 1'b0);
      send_item(OP_KEY, '0, '0, 32'h12345678, 1'b1);
      send_block(OP_ENC);

      // random part: mostly blocks, occasional key loads of random length
      for (int n = 0; n < 400; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            load_key($urandom_range(1, MAX_KEY_WORDS_DEF), 1'b0, 1'b0);
         else if (pick < 3)
            load_key(MAX_KEY_WORDS_DEF, 1'b1, 1'($urandom_range(0, 1)));
         else if (pick < 5)
            send_block(2'd3);
         else if (pick < 53)
            send_block(OP_ENC);
         else
            send_block(OP_DEC);
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
